// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, request and status codes, and the controller/datapath
// command and status bundles of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] REQ_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] REQ_POP_LEFT   = 2'd2;
  localparam logic [1:0] REQ_POP_RIGHT  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // update indices, count and store
    logic load_rd;   // take popped value from store read data
    logic out_load;  // move the finished result into the output register
  } deq_cmd_t;

  typedef struct packed {
    logic pop_ok;    // latched request is a pop that will succeed
    logic out_free;  // output register can take a result this cycle
  } deq_stat_t;

endpackage

// ----- rtl/deq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one request: capture, execute, optional store read,
// then hand-off into the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_rd  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.pop_ok ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd.load_rd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/deq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dpath
// Ring store with left/right end indices, entry count, held value and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module deq_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  deq_pkg::deq_cmd_t          cmd,
  output deq_pkg::deq_stat_t         stat,
  input  logic [1:0]                 in_req_type,
  input  logic signed [deq_pkg::DATA_W-1:0] in_push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] out_held_value,
  output logic [1:0]                 out_status,
  output logic                       out_is_empty
);

  localparam logic [deq_pkg::IDX_W-1:0] IDX_LAST = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::CNT_W-1:0] CNT_FULL = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [1:0]                  req_r;
  logic [deq_pkg::DATA_W-1:0]  val_r;
  logic [deq_pkg::IDX_W-1:0]   left_r,  left_nxt;
  logic [deq_pkg::IDX_W-1:0]   right_r, right_nxt;
  logic [deq_pkg::CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [deq_pkg::DATA_W-1:0]  last_r,  last_nxt;
  logic [1:0]                  st_r,    st_nxt;
  logic [deq_pkg::DATA_W-1:0]  mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0]  rdata_r;
  logic [deq_pkg::IDX_W-1:0]   rd_addr;
  logic [deq_pkg::IDX_W-1:0]   wr_addr;
  logic                        wr_en;
  logic [deq_pkg::IDX_W-1:0]   left_prev, left_next, right_prev, right_next;
  logic                        is_full, is_empty;
  logic                        out_valid_r;
  logic [deq_pkg::DATA_W-1:0]  out_val_r;
  logic [1:0]                  out_st_r;
  logic                        out_emp_r;

  assign left_prev  = (left_r  == '0)       ? IDX_LAST : left_r - 1'b1;
  assign left_next  = (left_r  == IDX_LAST) ? '0       : left_r + 1'b1;
  assign right_prev = (right_r == '0)       ? IDX_LAST : right_r - 1'b1;
  assign right_next = (right_r == IDX_LAST) ? '0       : right_r + 1'b1;
  assign is_full    = (cnt_r == CNT_FULL);
  assign is_empty   = (cnt_r == '0);

  assign stat.pop_ok   = req_r[1] && !is_empty;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    st_nxt    = st_r;
    wr_en     = 1'b0;
    wr_addr   = right_r;
    rd_addr   = left_r;
    if (cmd.exec) begin
      st_nxt = deq_pkg::ST_OK;
      case (req_r)
        deq_pkg::REQ_PUSH_LEFT: begin
          if (is_full) begin
            st_nxt = deq_pkg::ST_FULL;
          end else begin
            left_nxt = left_prev;
            wr_addr  = left_prev;
            wr_en    = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            last_nxt = val_r;
          end
        end
        deq_pkg::REQ_PUSH_RIGHT: begin
          if (is_full) begin
            st_nxt = deq_pkg::ST_FULL;
          end else begin
            right_nxt = right_next;
            wr_addr   = right_r;
            wr_en     = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            last_nxt  = val_r;
          end
        end
        deq_pkg::REQ_POP_LEFT: begin
          if (is_empty) begin
            st_nxt = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr  = left_r;
            left_nxt = left_next;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        deq_pkg::REQ_POP_RIGHT: begin
          if (is_empty) begin
            st_nxt = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr   = right_prev;
            right_nxt = right_prev;
            cnt_nxt   = cnt_r - 1'b1;
          end
        end
        default: begin
          st_nxt = deq_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.load_rd) begin
      last_nxt = rdata_r;
    end
  end

  // ring store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      val_r <= in_push_value;
    end
    if (cmd.out_load) begin
      out_val_r <= last_r;
      out_st_r  <= st_r;
      out_emp_r <= is_empty;
    end
    st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      right_r     <= '0;
      cnt_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_held_value = out_val_r;
  assign out_status     = out_st_r;
  assign out_is_empty   = out_emp_r;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries;
// push or pop at either end, one result per request.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | fields
//   in_     | input     | in_valid / in_ready   | req_type, push_value
//   out_    | output    | out_valid / out_ready | held_value, status, is_empty
//
// A push goes from capture through execute into the output register; a successful
// pop adds a load step for the registered read of the ring store.
// One request is in flight at a time; in_ready is high only while idle.
// A finished result waits in the output register while the next request runs.
// Synchronous active-low reset empties the queue and clears the held value.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic signed [deq_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] out_held_value,
  output logic [1:0]                        out_status,
  output logic                              out_is_empty
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_held_value (out_held_value),
    .out_status     (out_status),
    .out_is_empty   (out_is_empty)
  );

endmodule

// ----- rtl/deq_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks on the double-ended queue core.
// ----------------------------------------------------------------------------
module deq_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [deq_pkg::DATA_W-1:0] out_held_value,
  input logic [1:0]                 out_status,
  input logic                       out_is_empty
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_held_value) &&
    $stable(out_status) && $stable(out_is_empty))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == deq_pkg::ST_OK || out_status == deq_pkg::ST_EMPTY ||
    out_status == deq_pkg::ST_FULL)
    else $error("unknown status code");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == deq_pkg::ST_EMPTY |-> out_is_empty)
    else $error("pop from empty but queue not empty");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == deq_pkg::ST_FULL |-> !out_is_empty)
    else $error("push when full but queue empty");

  // one request in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while busy");

endmodule

bind double_ended_queue_core deq_chk u_deq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_held_value (out_held_value),
  .out_status     (out_status),
  .out_is_empty   (out_is_empty)
);
